>>> src/zsd_pkg.sv
`timescale 1ns / 1ps

package zsd_pkg;

    localparam int SumW = 32;

    // One element travelling down the cell chain
    typedef struct packed {
        logic            valid;
        logic [SumW-1:0] sum;    // prefix sum after this element
        logic            hit;    // match found so far along the chain
        logic            store;  // sum still looking for a free cell
        logic            ovf;    // element arrived with the store full
        logic            last;   // final element of the array
    } token_t;

endpackage

>>> src/zsd_if.sv
`timescale 1ns / 1ps

interface zsd_elem_if;
    import zsd_pkg::*;

    logic                   valid;
    logic                   ready;
    logic signed [SumW-1:0] element;
    logic                   last_element;

    modport source (output valid, output element, output last_element, input ready);
    modport sink (input valid, input element, input last_element, output ready);
endinterface

interface zsd_result_if;
    logic valid;
    logic ready;
    logic found;
    logic array_done;
    logic store_overflow;

    modport source (output valid, output found, output array_done, output store_overflow,
                    input ready);
    modport sink (input valid, input found, input array_done, input store_overflow,
                  output ready);
endinterface

>>> src/zsd_head.sv
`timescale 1ns / 1ps

module zsd_head #(
    parameter int MAX_LEN = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  logic                           in_valid,
    input  logic signed [zsd_pkg::SumW-1:0] element,
    input  logic                           last_element,
    output zsd_pkg::token_t                tok
);
    import zsd_pkg::*;

    localparam int CntW = $clog2(MAX_LEN + 1);

    logic [SumW-1:0] sum_reg;
    logic [SumW-1:0] sum_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    token_t          tok_reg;
    token_t          tok_next;
    logic [SumW-1:0] sum_new;
    logic            full;
    logic            accept;

    always_comb
    begin
        sum_new    = sum_reg + $unsigned(element);
        full       = (count_reg == CntW'(MAX_LEN));
        accept     = in_valid && advance;
        sum_next   = sum_reg;
        count_next = count_reg;
        tok_next   = tok_reg;
        if (accept)
        begin
            if (last_element)
            begin
                sum_next   = '0;
                count_next = '0;
            end
            else
            begin
                sum_next = sum_new;
                if (!full)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
        end
        if (advance)
        begin
            tok_next.valid = in_valid;
            tok_next.sum   = sum_new;
            tok_next.hit   = (sum_new == '0);
            tok_next.store = !full;
            tok_next.ovf   = full;
            tok_next.last  = last_element;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
            tok_reg   <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
            tok_reg   <= tok_next;
        end
    end

    assign tok = tok_reg;

endmodule

>>> src/zsd_cell.sv
`timescale 1ns / 1ps

module zsd_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  zsd_pkg::token_t tok_in,
    output zsd_pkg::token_t tok_out
);
    import zsd_pkg::*;

    logic            valid_reg;
    logic            valid_next;
    logic [SumW-1:0] sum_reg;
    logic [SumW-1:0] sum_next;
    token_t          tok_reg;
    token_t          tok_next;

    // Compare before store; the last element of an array empties the cell behind it
    always_comb
    begin
        valid_next = valid_reg;
        sum_next   = sum_reg;
        tok_next   = tok_reg;
        if (advance)
        begin
            tok_next = tok_in;
            if (tok_in.valid)
            begin
                tok_next.hit = tok_in.hit || (valid_reg && (sum_reg == tok_in.sum));
                if (tok_in.last)
                begin
                    valid_next = 1'b0;
                end
                else if (tok_in.store && !valid_reg)
                begin
                    valid_next     = 1'b1;
                    sum_next       = tok_in.sum;
                    tok_next.store = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    assign tok_out = tok_reg;

endmodule

>>> src/zsd_tail.sv
`timescale 1ns / 1ps

module zsd_tail (
    input  logic            clk,
    input  logic            rst_n,
    input  zsd_pkg::token_t tok_in,
    input  logic            out_ready,
    output logic            advance,
    output logic            out_valid,
    output logic            found,
    output logic            array_done,
    output logic            store_overflow
);
    import zsd_pkg::*;

    logic found_reg;
    logic found_next;
    logic ovf_reg;
    logic ovf_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic out_found_reg;
    logic out_found_next;
    logic out_done_reg;
    logic out_done_next;
    logic out_ovf_reg;
    logic out_ovf_next;
    logic load;

    always_comb
    begin
        advance        = !tok_in.valid || !out_valid_reg || out_ready;
        load           = advance && tok_in.valid;
        found_next     = found_reg;
        ovf_next       = ovf_reg;
        out_found_next = out_found_reg;
        out_done_next  = out_done_reg;
        out_ovf_next   = out_ovf_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_found_next = found_reg || tok_in.hit;
            out_ovf_next   = ovf_reg || tok_in.ovf;
            out_done_next  = tok_in.last;
            // Sticky flags, cleared at the end of an array
            found_next     = tok_in.last ? 1'b0 : (found_reg || tok_in.hit);
            ovf_next       = tok_in.last ? 1'b0 : (ovf_reg || tok_in.ovf);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            found_reg     <= found_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_found_reg <= out_found_next;
        out_done_reg  <= out_done_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign out_valid      = out_valid_reg;
    assign found          = out_found_reg;
    assign array_done     = out_done_reg;
    assign store_overflow = out_ovf_reg;

endmodule

>>> src/zero_sum_subarray_detector.sv
`timescale 1ns / 1ps
// Zero-sum subarray detector.
// Channel elem (sink): one signed 32-bit element per transaction, with
// last_element set on the final element of an array.
// Channel result (source): one transaction per element, in order, carrying
// found (a zero-sum subarray seen so far in this array), array_done (copy of
// last_element) and store_overflow (more than MAX_LEN elements in this array).
// The prefix sum is formed in a head stage, then travels through a chain of
// MAX_LEN cells, one cell per cycle while the chain advances; each cell compares
// against its stored sum and the first empty cell takes the new sum. An output
// register follows. A new element is taken every cycle while result does not stall,
// so throughput is one element per cycle.
// The last element empties every cell as it passes, so the next array may
// follow right behind it.
// Reset clears the prefix sum, element count, cell valid bits and flags; no
// clearing pass is needed and elem is ready on the first cycle after reset.
// When result stalls with a result held and a valid element at the end of the chain,
// the whole chain freezes and elem drops ready; bubbles in the chain still drain while the result waits.
module zero_sum_subarray_detector #(
    parameter int MAX_LEN = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    zsd_elem_if.sink            elem,
    zsd_result_if.source        result
);
    import zsd_pkg::*;

    token_t tok [0:MAX_LEN];
    logic   advance;

    zsd_head #(
        .MAX_LEN (MAX_LEN)
    ) u_head (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .in_valid     (elem.valid),
        .element      (elem.element),
        .last_element (elem.last_element),
        .tok          (tok[0])
    );

    for (genvar i = 0; i < MAX_LEN; i++)
    begin : g_cell
        zsd_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1])
        );
    end

    zsd_tail u_tail (
        .clk            (clk),
        .rst_n          (rst_n),
        .tok_in         (tok[MAX_LEN]),
        .out_ready      (result.ready),
        .advance        (advance),
        .out_valid      (result.valid),
        .found          (result.found),
        .array_done     (result.array_done),
        .store_overflow (result.store_overflow)
    );

    assign elem.ready = advance;

endmodule

>>> src/zsd_checker.sv
`timescale 1ns / 1ps

module zsd_protocol_checker #(
    parameter int MAX_LEN = 256
) (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic found,
    input logic array_done,
    input logic store_overflow
);
    localparam int CntW = $clog2(MAX_LEN + 4) + 1;

    logic [CntW-1:0] pending_reg;
    logic [CntW-1:0] pending_next;
    logic            prev_found_reg;
    logic            prev_ovf_reg;
    logic            prev_done_reg;
    logic            in_xact;
    logic            out_xact;

    always_comb
    begin
        in_xact      = in_valid && in_ready;
        out_xact     = out_valid && out_ready;
        pending_next = pending_reg;
        if (in_xact && !out_xact)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (out_xact && !in_xact)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg    <= '0;
            prev_found_reg <= 1'b0;
            prev_ovf_reg   <= 1'b0;
            prev_done_reg  <= 1'b1;
        end
        else
        begin
            pending_reg <= pending_next;
            if (out_xact)
            begin
                prev_found_reg <= found;
                prev_ovf_reg   <= store_overflow;
                prev_done_reg  <= array_done;
            end
        end
    end

    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(found)
            && $stable(array_done) && $stable(store_overflow))
        else $error("result changed while stalled");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != '0)
        else $error("result without a pending element");

    a_found_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && prev_found_reg && !prev_done_reg |-> found)
        else $error("found dropped inside an array");

    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && prev_ovf_reg && !prev_done_reg |-> store_overflow)
        else $error("store_overflow dropped inside an array");

endmodule

bind zero_sum_subarray_detector zsd_protocol_checker #(
    .MAX_LEN (MAX_LEN)
) u_zsd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (elem.valid),
    .in_ready       (elem.ready),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .found          (result.found),
    .array_done     (result.array_done),
    .store_overflow (result.store_overflow)
);
